// ----- src/aavr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, stage map and the per-stage step function of the axis-angle rotator.
// Used by aavr_stage, axis_angle_vector_rotate_core and the bench; depends on nothing else.
package aavr_pkg;

    localparam int ATAN_ENTRIES        = 24;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    // Stage map of the pipeline.
    localparam int INIT_STAGE  = 0;
    localparam int SQRT_FIRST  = 1;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_INIT    = SQRT_FIRST + SQRT_STEPS;
    localparam int DIV_FIRST   = DIV_INIT + 1;
    localparam int DIV_STEPS   = 31;
    localparam int UNIT_STAGE  = DIV_FIRST + DIV_STEPS;
    localparam int TERM_STAGE  = UNIT_STAGE + 1;
    localparam int CROSS_STAGE = TERM_STAGE + 1;
    localparam int MAT_STAGE   = CROSS_STAGE + 1;
    localparam int PROD_STAGE  = MAT_STAGE + 1;
    localparam int SUM_STAGE   = PROD_STAGE + 1;
    localparam int NUM_STAGES  = SUM_STAGE + 1;

    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [35:0] NEG_ONE_Q30 = -36'sd1073741824;
    localparam logic signed [35:0] CORDIC_GAIN = 36'sd652032874;
    localparam logic signed [65:0] ROUND_HALF  = 66'sd536870912;
    localparam logic signed [65:0] OUT_MAX     = 66'sd2147483647;
    localparam logic signed [65:0] OUT_MIN     = -66'sd2147483648;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [30:0] ATAN_TURN [ATAN_ENTRIES] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
        31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
        31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163, 31'd81
    };

    typedef logic signed [35:0] q30_t;

    typedef struct packed {
        logic [2:0][15:0] axis;
        logic [15:0]      angle;
        logic [2:0][31:0] pt;
        logic [63:0]      rad;
        logic [63:0]      root;
        logic             zero_axis;
        q30_t             cx;
        q30_t             cy;
        logic signed [32:0] cz;
        logic             flip;
        logic [31:0]      divisor;
        logic [2:0][32:0] rem;
        logic [2:0][30:0] quo;
        logic [2:0][35:0] u;
        q30_t             s;
        q30_t             c;
        q30_t             oc;
        logic [2:0][35:0] t;
        logic [2:0][35:0] sp;
        logic [2:0][35:0] dg;
        logic [2:0][35:0] off;
        logic [8:0][31:0] m;
        logic [8:0][63:0] prod;
        logic [2:0][31:0] rot;
        logic             clip;
    } item_t;

    function automatic q30_t mul30(input q30_t a, input q30_t b);
        logic signed [71:0] full;
        full = 72'(a) * 72'(b);
        return 36'(full >>> 30);
    endfunction

    function automatic logic [31:0] clamp_unit(input q30_t v);
        q30_t r;
        r = v;
        if (v > ONE_Q30)
        begin
            r = ONE_Q30;
        end
        else if (v < NEG_ONE_Q30)
        begin
            r = NEG_ONE_Q30;
        end
        return r[31:0];
    endfunction

    // Work done by pipeline stage k on one word; cs is the CORDIC iteration count.
    function automatic item_t aavr_step(input int k, input int cs, input item_t d);
        item_t              o;
        int                 i;
        int                 n;
        logic [63:0]        bitv;
        logic [63:0]        trial;
        logic [31:0]        turn;
        logic signed [31:0] a2 [3];
        logic [33:0]        sq;
        q30_t               dx;
        q30_t               dy;
        logic [15:0]        mag;
        logic [32:0]        shl;
        logic [30:0]        uq;
        q30_t               uv;
        logic signed [65:0] acc;
        logic signed [65:0] rs;
        o = d;
        n = (cs < ATAN_ENTRIES) ? cs : ATAN_ENTRIES;
        if (k == INIT_STAGE)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a2[c] = 32'($signed(d.axis[c])) * 32'($signed(d.axis[c]));
            end
            sq = 34'(a2[0]) + 34'(a2[1]) + 34'(a2[2]);
            o.rad = {sq[31:0], 32'd0};
            o.root = '0;
            o.zero_axis = (sq == '0);
            // Fold the second and third quadrants by a half turn.
            turn = {d.angle, 16'd0};
            o.flip = d.angle[15] ^ d.angle[14];
            if (o.flip)
            begin
                turn = turn - 32'h8000_0000;
            end
            o.cz = $signed({turn[31], turn});
            o.cx = CORDIC_GAIN;
            o.cy = '0;
        end
        if (k >= SQRT_FIRST && k < SQRT_FIRST + SQRT_STEPS)
        begin
            i = k - SQRT_FIRST;
            bitv = 64'd1 << (62 - 2 * i);
            trial = d.root + bitv;
            if (d.rad >= trial)
            begin
                o.rad = d.rad - trial;
                o.root = (d.root >> 1) + bitv;
            end
            else
            begin
                o.root = d.root >> 1;
            end
        end
        // CORDIC iterations share the square-root stages.
        if (k >= SQRT_FIRST && k - SQRT_FIRST < n)
        begin
            i = k - SQRT_FIRST;
            dx = d.cy >>> i;
            dy = d.cx >>> i;
            if (!d.cz[32])
            begin
                o.cx = d.cx - dx;
                o.cy = d.cy + dy;
                o.cz = d.cz - $signed({2'b00, ATAN_TURN[i]});
            end
            else
            begin
                o.cx = d.cx + dx;
                o.cy = d.cy - dy;
                o.cz = d.cz + $signed({2'b00, ATAN_TURN[i]});
            end
        end
        if (k == DIV_INIT)
        begin
            o.divisor = d.root[31:0];
            for (int c = 0; c < 3; c++)
            begin
                mag = d.axis[c][15] ? (~d.axis[c] + 16'd1) : d.axis[c];
                o.rem[c] = {2'b00, mag, 15'd0};
                o.quo[c] = '0;
            end
            o.c = d.flip ? -d.cx : d.cx;
            o.s = d.flip ? -d.cy : d.cy;
            o.oc = ONE_Q30 - (d.flip ? -d.cx : d.cx);
        end
        if (k >= DIV_FIRST && k < DIV_FIRST + DIV_STEPS)
        begin
            for (int c = 0; c < 3; c++)
            begin
                shl = {d.rem[c][31:0], 1'b0};
                if (shl >= {1'b0, d.divisor})
                begin
                    o.rem[c] = shl - {1'b0, d.divisor};
                    o.quo[c] = {d.quo[c][29:0], 1'b1};
                end
                else
                begin
                    o.rem[c] = shl;
                    o.quo[c] = {d.quo[c][29:0], 1'b0};
                end
            end
        end
        if (k == UNIT_STAGE)
        begin
            for (int c = 0; c < 3; c++)
            begin
                uq = (d.quo[c] > 31'(ONE_Q30)) ? 31'(ONE_Q30) : d.quo[c];
                uv = $signed({5'b00000, uq});
                if (d.zero_axis)
                begin
                    o.u[c] = '0;
                end
                else
                begin
                    o.u[c] = d.axis[c][15] ? -uv : uv;
                end
            end
        end
        if (k == TERM_STAGE)
        begin
            for (int c = 0; c < 3; c++)
            begin
                o.t[c] = mul30(d.oc, $signed(d.u[c]));
                o.sp[c] = mul30($signed(d.u[c]), d.s);
            end
        end
        if (k == CROSS_STAGE)
        begin
            for (int c = 0; c < 3; c++)
            begin
                o.dg[c] = mul30($signed(d.t[c]), $signed(d.u[c]));
            end
            o.off[0] = mul30($signed(d.t[0]), $signed(d.u[1]));
            o.off[1] = mul30($signed(d.t[2]), $signed(d.u[0]));
            o.off[2] = mul30($signed(d.t[1]), $signed(d.u[2]));
        end
        if (k == MAT_STAGE)
        begin
            o.m[0] = clamp_unit($signed(d.dg[0]) + d.c);
            o.m[1] = clamp_unit($signed(d.off[0]) - $signed(d.sp[2]));
            o.m[2] = clamp_unit($signed(d.off[1]) + $signed(d.sp[1]));
            o.m[3] = clamp_unit($signed(d.off[0]) + $signed(d.sp[2]));
            o.m[4] = clamp_unit($signed(d.dg[1]) + d.c);
            o.m[5] = clamp_unit($signed(d.off[2]) - $signed(d.sp[0]));
            o.m[6] = clamp_unit($signed(d.off[1]) - $signed(d.sp[1]));
            o.m[7] = clamp_unit($signed(d.off[2]) + $signed(d.sp[0]));
            o.m[8] = clamp_unit($signed(d.dg[2]) + d.c);
        end
        if (k == PROD_STAGE)
        begin
            // Output j takes column j of the matrix.
            for (int j = 0; j < 3; j++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    o.prod[3 * j + c] = 64'($signed(d.m[3 * c + j])) * 64'($signed(d.pt[c]));
                end
            end
        end
        if (k == SUM_STAGE)
        begin
            o.clip = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                acc = 66'($signed(d.prod[3 * j])) + 66'($signed(d.prod[3 * j + 1]))
                    + 66'($signed(d.prod[3 * j + 2])) + ROUND_HALF;
                rs = acc >>> 30;
                if (rs > OUT_MAX)
                begin
                    o.rot[j] = OUT_MAX[31:0];
                    o.clip = 1'b1;
                end
                else if (rs < OUT_MIN)
                begin
                    o.rot[j] = OUT_MIN[31:0];
                    o.clip = 1'b1;
                end
                else
                begin
                    o.rot[j] = rs[31:0];
                end
            end
        end
        return o;
    endfunction

endpackage

// ----- src/aavr_stage.sv -----
`timescale 1ns / 1ps
// One register stage of the rotator pipeline with its own valid bit and stall.
// Depends on aavr_pkg for the word type and the step function.
module aavr_stage
    import aavr_pkg::*;
#(
    parameter int STAGE        = 0,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  item_t up_data,
    output logic  up_stall,
    output logic  dn_valid,
    output item_t dn_data,
    input  logic  dn_stall
);

    logic  valid_reg;
    item_t data_reg;
    item_t data_next;

    // A stage holds only when it is full and its successor holds.
    assign up_stall  = valid_reg && dn_stall;
    assign data_next = aavr_step(STAGE, CORDIC_STEPS, up_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ----- src/axis_angle_vector_rotate_core.sv -----
`timescale 1ns / 1ps
// Throughput: one word per cycle while item_stall is low. The 71 stages do the set-up,
// one root bit, one quotient bit, the divider set-up, the unit vector or one product
// level, with CORDIC steps riding on the root stages.
// A stall holds only full stages, so empty slots still fill behind a held result.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
module axis_angle_vector_rotate_core
    import aavr_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic [15:0]        angle,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] rotated_x,
    output logic signed [31:0] rotated_y,
    output logic signed [31:0] rotated_z,
    output logic               clipped
);

    item_t chain_data  [NUM_STAGES + 1];
    logic  chain_valid [NUM_STAGES + 1];
    logic  chain_stall [NUM_STAGES + 1];

    always_comb
    begin
        chain_data[0]         = '0;
        chain_data[0].axis[0] = axis_x;
        chain_data[0].axis[1] = axis_y;
        chain_data[0].axis[2] = axis_z;
        chain_data[0].angle   = angle;
        chain_data[0].pt[0]   = point_x;
        chain_data[0].pt[1]   = point_y;
        chain_data[0].pt[2]   = point_z;
    end

    assign chain_valid[0]          = item_valid;
    assign item_stall              = chain_stall[0];
    assign chain_stall[NUM_STAGES] = result_stall;

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++)
        begin : g_stage
            aavr_stage #(
                .STAGE        (g),
                .CORDIC_STEPS (CORDIC_STEPS)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (chain_valid[g]),
                .up_data  (chain_data[g]),
                .up_stall (chain_stall[g]),
                .dn_valid (chain_valid[g + 1]),
                .dn_data  (chain_data[g + 1]),
                .dn_stall (chain_stall[g + 1])
            );
        end
    endgenerate

    assign result_valid = chain_valid[NUM_STAGES];
    assign rotated_x    = $signed(chain_data[NUM_STAGES].rot[0]);
    assign rotated_y    = $signed(chain_data[NUM_STAGES].rot[1]);
    assign rotated_z    = $signed(chain_data[NUM_STAGES].rot[2]);
    assign clipped      = chain_data[NUM_STAGES].clip;

`ifndef SYNTHESIS
    // Back pressure at the input can only come from a held result.
    a_stall_origin: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a held result");

    // A clip flag always comes with a saturated component.
    a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped) |->
            (rotated_x == 32'sh7fff_ffff || rotated_x == -32'sh8000_0000 ||
             rotated_y == 32'sh7fff_ffff || rotated_y == -32'sh8000_0000 ||
             rotated_z == 32'sh7fff_ffff || rotated_z == -32'sh8000_0000))
        else $error("clip flag without a saturated component");
`endif

endmodule

// ----- bench/axis_angle_vector_rotate_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for axis_angle_vector_rotate_core: random and directed rotations
// checked against an in-bench fixed-point predictor. Depends on aavr_pkg and the core.
module axis_angle_vector_rotate_core_test;
    import aavr_pkg::*;

    localparam int STEPS = 16;
    localparam int PIPE_DEPTH = 71;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        clip;
    } rotation_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [15:0]        angle;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic               clipped;

    rotation_t expected_rotations[$];
    int        error_count;
    int        stall_mode;

    axis_angle_vector_rotate_core #(.CORDIC_STEPS(STEPS)) u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .axis_x(axis_x),
        .axis_y(axis_y),
        .axis_z(axis_z),
        .angle(angle),
        .point_x(point_x),
        .point_y(point_y),
        .point_z(point_z),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .rotated_x(rotated_x),
        .rotated_y(rotated_y),
        .rotated_z(rotated_z),
        .clipped(clipped)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

    // Floor division by 2^30; >>> on signed longint rounds toward minus infinity.
    function automatic longint fmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint unit_clamp(input longint v);
        if (v > 64'sd1073741824)
        begin
            return 64'sd1073741824;
        end
        if (v < -64'sd1073741824)
        begin
            return -64'sd1073741824;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint unit_component(input longint a, input longint r);
        longint unsigned mag;
        longint          u;
        if (r == 0)
        begin
            return 0;
        end
        mag = (a < 0) ? -a : a;
        u = longint'((mag << 46) / longint'(r));
        if (u > 64'sd1073741824)
        begin
            u = 64'sd1073741824;
        end
        return (a < 0) ? -u : u;
    endfunction

    function automatic logic [31:0] round_saturate(input longint m0, input longint m1,
        input longint m2, input longint px, input longint py, input longint pz,
        inout logic clip);
        logic signed [65:0] acc;
        logic signed [65:0] r;
        acc = 66'(m0) * 66'(px) + 66'(m1) * 66'(py) + 66'(m2) * 66'(pz) + 66'sd536870912;
        r = acc >>> 30;
        if (r > 66'sd2147483647)
        begin
            clip = 1'b1;
            return 32'h7fff_ffff;
        end
        if (r < -66'sd2147483648)
        begin
            clip = 1'b1;
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    function automatic rotation_t predict_rotation(input logic signed [15:0] ax,
        input logic signed [15:0] ay, input logic signed [15:0] az, input logic [15:0] ang,
        input logic signed [31:0] px, input logic signed [31:0] py,
        input logic signed [31:0] pz);
        rotation_t      res;
        longint         r;
        longint         ux;
        longint         uy;
        longint         uz;
        longint         cx;
        longint         cy;
        longint         cz;
        longint         dx;
        longint         dy;
        longint         s;
        longint         c;
        longint         oc;
        longint         tx;
        longint         ty;
        longint         tz;
        longint         xy;
        longint         zx;
        longint         yz;
        longint         xs;
        longint         ys;
        longint         zs;
        longint         m[9];
        logic [31:0]    turn;
        logic           flip;
        longint unsigned sq;
        sq = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        r = int_sqrt(sq << 32);
        ux = unit_component(ax, r);
        uy = unit_component(ay, r);
        uz = unit_component(az, r);
        turn = {ang, 16'd0};
        flip = ang[15] ^ ang[14];
        if (flip)
        begin
            turn = turn - 32'h8000_0000;
        end
        cz = longint'($signed(turn));
        cx = 652032874;
        cy = 0;
        for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - longint'(ATAN_TURN[i]);
            end
            else
            begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + longint'(ATAN_TURN[i]);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        oc = 64'sd1073741824 - c;
        tx = fmul(oc, ux);
        ty = fmul(oc, uy);
        tz = fmul(oc, uz);
        xy = fmul(tx, uy);
        zx = fmul(tz, ux);
        yz = fmul(ty, uz);
        xs = fmul(ux, s);
        ys = fmul(uy, s);
        zs = fmul(uz, s);
        m[0] = unit_clamp(fmul(tx, ux) + c);
        m[1] = unit_clamp(xy - zs);
        m[2] = unit_clamp(zx + ys);
        m[3] = unit_clamp(xy + zs);
        m[4] = unit_clamp(fmul(ty, uy) + c);
        m[5] = unit_clamp(yz - xs);
        m[6] = unit_clamp(zx - ys);
        m[7] = unit_clamp(yz + xs);
        m[8] = unit_clamp(fmul(tz, uz) + c);
        res.clip = 1'b0;
        res.x = round_saturate(m[0], m[3], m[6], px, py, pz, res.clip);
        res.y = round_saturate(m[1], m[4], m[7], px, py, pz, res.clip);
        res.z = round_saturate(m[2], m[5], m[8], px, py, pz, res.clip);
        return res;
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 6)
        begin
            return 0;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 80);
    endfunction

    // Sends one word and waits for its acceptance; the predictor runs at acceptance.
    task automatic send_word(input logic signed [15:0] ax, input logic signed [15:0] ay,
        input logic signed [15:0] az, input logic [15:0] ang, input logic signed [31:0] px,
        input logic signed [31:0] py, input logic signed [31:0] pz, input bit gaps);
        int gap;
        gap = gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        axis_x <= ax;
        axis_y <= ay;
        axis_z <= az;
        angle <= ang;
        point_x <= px;
        point_y <= py;
        point_z <= pz;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        expected_rotations.push_back(predict_rotation(ax, ay, az, ang, px, py, pz));
    endtask

    task automatic go_idle();
        item_valid <= 1'b0;
    endtask

    task automatic drain_results();
        go_idle();
        while (expected_rotations.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] random_point();
        case ($urandom_range(0, 5))
            0: return $signed($urandom());
            1: return 32'sh7fff_ffff;
            2: return 32'sh8000_0000;
            default: return $signed(32'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000);
        endcase
    endfunction

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return $signed(16'($urandom_range(0, 15)) - 16'd8);
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] quarter_angles[8];
        quarter_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h3fff, 16'h4001,
                           16'hbfff, 16'hffff};
        foreach (quarter_angles[i])
        begin
            send_word(16'sd0, 16'sd0, 16'sd1, quarter_angles[i], 32'sh0001_0000,
                      32'sh0002_0000, -32'sh0003_0000, 1'b0);
        end
        // A zero axis leaves only the cosine scaling of the point.
        send_word(16'sd0, 16'sd0, 16'sd0, 16'h2000, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sd12345, 1'b0);
        send_word(16'sd0, 16'sd0, 16'sd0, 16'h8000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 1'b0);
        send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'h1555, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'h6000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_word(16'sh8000, 16'sd0, 16'sd0, 16'h4000, 32'sd0, 32'sh7fff_ffff, 32'sd0, 1'b0);
        send_word(16'sh7fff, 16'sh8000, 16'sd1, 16'hffff, 32'shffff_ffff, 32'sd1,
                  32'sh8000_0000, 1'b0);
        send_word(16'sd1, 16'sd0, 16'sd0, 16'h2aaa, 32'sh0000_8000, -32'sh0000_8000, 32'sd0, 1'b0);
        send_word(16'sd0, -16'sd1, 16'sd0, 16'he000, 32'sh5555_5555, 32'shaaaa_aaaa,
                  32'sh5555_5555, 1'b0);
        send_word(16'sd3, 16'sd4, 16'sd0, 16'h7fff, 32'sh7fff_ffff, 32'sh8000_0000,
                  32'sh7fff_ffff, 1'b0);
        drain_results();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_word(random_axis(), random_axis(), random_axis(), 16'($urandom()),
                      random_point(), random_point(), random_point(), n % 300 >= 100);
            // Hold off once so the pipeline empties completely mid-stream.
            if (n == count / 2)
            begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial
    begin
        error_count = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        axis_x = '0;
        axis_y = '0;
        axis_z = '0;
        angle = '0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_mode = 1;
        test_random(1400);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0 && expected_rotations.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Receiver stall: short random stalls, occasional long ones, none in some phases.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_mode == 0 || $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                result_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        rotation_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_rotations.size() == 0)
            begin
                $error("unexpected word: x %h y %h z %h", rotated_x, rotated_y, rotated_z);
                error_count++;
            end
            else
            begin
                want = expected_rotations.pop_front();
                if (rotated_x !== want.x)
                begin
                    $error("rotated_x expected %h actual %h", want.x, rotated_x);
                    error_count++;
                end
                if (rotated_y !== want.y)
                begin
                    $error("rotated_y expected %h actual %h", want.y, rotated_y);
                    error_count++;
                end
                if (rotated_z !== want.z)
                begin
                    $error("rotated_z expected %h actual %h", want.z, rotated_z);
                    error_count++;
                end
                if (clipped !== want.clip)
                begin
                    $error("clipped expected %b actual %b", want.clip, clipped);
                    error_count++;
                end
            end
        end
    end

endmodule
